// ===== sv/mec_pkg.sv =====
// mec_pkg: shared constants and types of the multiset equality check
// field widths, command codes and default store depth; no dependencies
package mec_pkg;

	localparam int MAX_ELEMENTS_DEFAULT = 256;
	localparam int CMD_W = 2;
	localparam int SLOT_W = 8;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_FIRST = 2'd0,
		CMD_LOAD_SECOND = 2'd1,
		CMD_COMPARE = 2'd2
	} cmd_t;

endpackage

// ===== sv/mec_ram.sv =====
// mec_ram: generic single-write, single-read RAM with registered read data
// no dependencies; used for the element stores and the matched bitmap
module mec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/multiset_equality_check.sv =====
// multiset_equality_check: top level, load sequencer and compare engine
// depends on mec_pkg and mec_ram (two element stores and the matched bitmap)
//
// A load transfer writes one element into the first or second store when its slot is below
// MAX_ELEMENTS, and the block stays ready. A compare transfer works on n = min(element_count,
// MAX_ELEMENTS) elements: it first clears the matched bitmap, then fetches each first-store
// element (S_A_RD, S_A_LAT) and scans the second store (S_B_RD, S_B_CMP per entry), since
// the single equality comparator waits on the registered read of the second store and bitmap.
// The scan for an element stops at its first unmatched equal entry or at the last entry.
// A zero length goes straight to the done state; no new item is taken while a compare runs.
// The result sits in an output register, so loads keep flowing while it waits; a finished
// compare holds until the previous result is taken.
module multiset_equality_check
	import mec_pkg::*;
#(
	parameter int MAX_ELEMENTS = mec_pkg::MAX_ELEMENTS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mec_pkg::CMD_W-1:0]         cmd,
	input  logic [mec_pkg::SLOT_W-1:0]        slot,
	input  logic signed [mec_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              arrays_equal,
	output logic [mec_pkg::COUNT_W-1:0]       match_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mec_pkg::COUNT_W-1:0]       cfg_data
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_A_RD,
		S_A_LAT,
		S_B_RD,
		S_B_CMP,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   element_count_q;
	logic [COUNT_W-1:0]   n_q;
	logic [COUNT_W-1:0]   a_q;
	logic [COUNT_W-1:0]   b_q;
	logic [COUNT_W-1:0]   hits_q;
	logic [VALUE_W-1:0]   want_q;

	logic                 in_xfer;
	logic                 slot_ok;
	logic [COUNT_W-1:0]   n_cap;
	logic                 hit;
	logic                 b_last;
	logic                 a_last;
	logic                 out_load;

	logic                 first_wr_en;
	logic                 second_wr_en;
	logic                 first_rd_en;
	logic                 scan_rd_en;
	logic [VALUE_W-1:0]   first_rd_data;
	logic [VALUE_W-1:0]   second_rd_data;
	logic                 mark_wr_en;
	logic                 mark_wr_data;
	logic                 mark_rd_data;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign slot_ok   = (32'(slot) < MAX_ELEMENTS);
	assign out_load  = (state_q == S_DONE) && (!out_valid || out_ready);

	always_comb begin
		if (32'(element_count_q) > MAX_ELEMENTS) begin
			n_cap = COUNT_W'(MAX_ELEMENTS);
		end else begin
			n_cap = element_count_q;
		end
	end

	assign b_last = (b_q == n_q - 1'b1);
	assign a_last = (a_q == n_q - 1'b1);
	assign hit    = (state_q == S_B_CMP) && !mark_rd_data && (second_rd_data == want_q);

	assign first_wr_en  = in_xfer && (cmd == CMD_LOAD_FIRST) && slot_ok;
	assign second_wr_en = in_xfer && (cmd == CMD_LOAD_SECOND) && slot_ok;
	assign first_rd_en  = (state_q == S_A_RD);
	assign scan_rd_en   = (state_q == S_B_RD);
	assign mark_wr_en   = (state_q == S_CLEAR) || hit;
	assign mark_wr_data = hit;

	mec_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ELEMENTS)
	) u_first_store (
		.clk(clk),
		.wr_en(first_wr_en),
		.wr_addr(AW'(slot)),
		.wr_data(value),
		.rd_en(first_rd_en),
		.rd_addr(AW'(a_q)),
		.rd_data(first_rd_data)
	);

	mec_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ELEMENTS)
	) u_second_store (
		.clk(clk),
		.wr_en(second_wr_en),
		.wr_addr(AW'(slot)),
		.wr_data(value),
		.rd_en(scan_rd_en),
		.rd_addr(AW'(b_q)),
		.rd_data(second_rd_data)
	);

	mec_ram #(
		.WIDTH(1),
		.DEPTH(MAX_ELEMENTS)
	) u_matched_bits (
		.clk(clk),
		.wr_en(mark_wr_en),
		.wr_addr(AW'(b_q)),
		.wr_data(mark_wr_data),
		.rd_en(scan_rd_en),
		.rd_addr(AW'(b_q)),
		.rd_data(mark_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			element_count_q <= '0;
			out_valid       <= 1'b0;
			arrays_equal    <= 1'b0;
			match_count     <= '0;
			n_q             <= '0;
			a_q             <= '0;
			b_q             <= '0;
			hits_q          <= '0;
			want_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				element_count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (cmd == CMD_COMPARE)) begin
						n_q    <= n_cap;
						hits_q <= '0;
						b_q    <= '0;
						a_q    <= '0;
						if (n_cap == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_CLEAR;
						end
					end
				end
				S_CLEAR: begin
					if (b_last) begin
						a_q     <= '0;
						state_q <= S_A_RD;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				S_A_RD: begin
					state_q <= S_A_LAT;
				end
				S_A_LAT: begin
					want_q  <= first_rd_data;
					b_q     <= '0;
					state_q <= S_B_RD;
				end
				S_B_RD: begin
					state_q <= S_B_CMP;
				end
				S_B_CMP: begin
					if (hit) begin
						hits_q <= hits_q + 1'b1;
					end
					if (hit || b_last) begin
						if (a_last) begin
							state_q <= S_DONE;
						end else begin
							a_q     <= a_q + 1'b1;
							state_q <= S_A_RD;
						end
					end else begin
						b_q     <= b_q + 1'b1;
						state_q <= S_B_RD;
					end
				end
				S_DONE: begin
					if (out_load) begin
						arrays_equal <= (hits_q == n_q);
						match_count  <= hits_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
